/* src/ssi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

    localparam int SET_DEPTH = 32;
    localparam int ADDR_W    = $clog2(SET_DEPTH);
    localparam int CNT_W     = 6;
    localparam int STEP_W    = 7;
    localparam int DATA_W    = 32;

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_RUN    = 2'd2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SET_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } walk_state_t;

endpackage

`default_nettype wire

/* src/ssi_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssi_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/sorted_set_intersection_top.sv */
// Sorted set intersection.
// Input words carry req_type and value. Load A / load B append value to
// list A or B; words beyond SET_DEPTH per list are dropped.
// A run word walks both lists with two pointers and emits one output word
// per common value (has_match = 1), then a summary word (is_last = 1) that
// holds the total number of comparison steps. Both lists are then empty.
// Each comparison step is a list read followed by a compare, since the two
// list memories have a registered read; steps <= 2 * SET_DEPTH - 1.
// The input is taken again once the summary word sits in the output register.
// Load words are accepted while an output word still waits.
// Results pass through a one-word output register; while it holds a word
// and out_ready is low the walk pauses at the next match or at the summary.
// Reset (rst_n low) empties both lists and drops any pending output word.
// Request code 3 is accepted and ignored.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_intersection_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      match_value,
    output logic                    has_match,
    output logic                    is_last,
    output logic [6:0]              compare_count
);

    localparam int AW = ssi_pkg::ADDR_W;
    localparam int CW = ssi_pkg::CNT_W;
    localparam int SW = ssi_pkg::STEP_W;
    localparam int DW = ssi_pkg::DATA_W;

    ssi_pkg::walk_state_t state_reg, state_next;

    logic [CW-1:0] a_count_reg, a_count_next;
    logic [CW-1:0] b_count_reg, b_count_next;
    logic [CW-1:0] ia_reg, ia_next;
    logic [CW-1:0] ib_reg, ib_next;
    logic [SW-1:0] steps_reg, steps_next;

    logic              out_valid_reg, out_valid_next;
    logic signed [31:0] match_value_reg, match_value_next;
    logic              has_match_reg, has_match_next;
    logic              is_last_reg, is_last_next;
    logic [6:0]        compare_count_reg, compare_count_next;
    logic              out_load;

    logic          in_fire;
    logic          can_emit;
    logic          rd_en;
    logic          a_we, b_we;
    logic [DW-1:0] a_rdata, b_rdata;
    logic          eq, b_lt;

    ssi_ram #(
        .WIDTH (DW),
        .DEPTH (ssi_pkg::SET_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_count_reg[AW-1:0]),
        .wdata (value),
        .re    (rd_en),
        .raddr (ia_reg[AW-1:0]),
        .rdata (a_rdata)
    );

    ssi_ram #(
        .WIDTH (DW),
        .DEPTH (ssi_pkg::SET_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_count_reg[AW-1:0]),
        .wdata (value),
        .re    (rd_en),
        .raddr (ib_reg[AW-1:0]),
        .rdata (b_rdata)
    );

    assign in_fire  = in_valid && in_ready;
    assign can_emit = !out_valid_reg || out_ready;
    assign eq       = (a_rdata == b_rdata);
    assign b_lt     = ($signed(b_rdata) < $signed(a_rdata));

    // FSM outputs
    always_comb
    begin
        in_ready = (state_reg == ssi_pkg::ST_IDLE);
        rd_en    = (state_reg == ssi_pkg::ST_READ);
        a_we     = in_fire && (req_type == ssi_pkg::REQ_LOAD_A)
                   && (a_count_reg < ssi_pkg::DEPTH_CNT);
        b_we     = in_fire && (req_type == ssi_pkg::REQ_LOAD_B)
                   && (b_count_reg < ssi_pkg::DEPTH_CNT);
    end

    // next state and datapath
    always_comb
    begin
        logic [CW-1:0] ia_adv;
        logic [CW-1:0] ib_adv;
        ia_adv             = ia_reg + CW'(1);
        ib_adv             = ib_reg + CW'(1);
        state_next         = state_reg;
        a_count_next       = a_count_reg;
        b_count_next       = b_count_reg;
        ia_next            = ia_reg;
        ib_next            = ib_reg;
        steps_next         = steps_reg;
        out_load           = 1'b0;
        match_value_next   = match_value_reg;
        has_match_next     = has_match_reg;
        is_last_next       = is_last_reg;
        compare_count_next = compare_count_reg;

        case (state_reg)
            ssi_pkg::ST_IDLE:
            begin
                if (a_we)
                begin
                    a_count_next = a_count_reg + CW'(1);
                end
                if (b_we)
                begin
                    b_count_next = b_count_reg + CW'(1);
                end
                if (in_fire && (req_type == ssi_pkg::REQ_RUN))
                begin
                    ia_next    = '0;
                    ib_next    = '0;
                    steps_next = '0;
                    if ((a_count_reg == '0) || (b_count_reg == '0))
                    begin
                        state_next = ssi_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ssi_pkg::ST_READ;
                    end
                end
            end
            ssi_pkg::ST_READ:
            begin
                state_next = ssi_pkg::ST_CMP;
            end
            ssi_pkg::ST_CMP:
            begin
                // hold on a match until the output register frees up
                if (!eq || can_emit)
                begin
                    steps_next = steps_reg + SW'(1);
                    if (eq)
                    begin
                        out_load           = 1'b1;
                        match_value_next   = $signed(a_rdata);
                        has_match_next     = 1'b1;
                        is_last_next       = 1'b0;
                        compare_count_next = steps_reg + SW'(1);
                        ia_next            = ia_adv;
                        ib_next            = ib_adv;
                    end
                    else if (b_lt)
                    begin
                        ib_next = ib_adv;
                    end
                    else
                    begin
                        ia_next = ia_adv;
                    end
                    if ((ia_next == a_count_reg) || (ib_next == b_count_reg))
                    begin
                        state_next = ssi_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ssi_pkg::ST_READ;
                    end
                end
            end
            ssi_pkg::ST_DONE:
            begin
                if (can_emit)
                begin
                    out_load           = 1'b1;
                    match_value_next   = '0;
                    has_match_next     = 1'b0;
                    is_last_next       = 1'b1;
                    compare_count_next = steps_reg;
                    a_count_next       = '0;
                    b_count_next       = '0;
                    state_next         = ssi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssi_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssi_pkg::ST_IDLE;
            a_count_reg   <= '0;
            b_count_reg   <= '0;
            ia_reg        <= '0;
            ib_reg        <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_count_reg   <= a_count_next;
            b_count_reg   <= b_count_next;
            ia_reg        <= ia_next;
            ib_reg        <= ib_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_value_reg   <= match_value_next;
        has_match_reg     <= has_match_next;
        is_last_reg       <= is_last_next;
        compare_count_reg <= compare_count_next;
    end

    assign out_valid     = out_valid_reg;
    assign match_value   = match_value_reg;
    assign has_match     = has_match_reg;
    assign is_last       = is_last_reg;
    assign compare_count = compare_count_reg;

`ifndef SYNTHESIS
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssi_pkg::ST_READ) |->
            ((ia_reg < a_count_reg) && (ib_reg < b_count_reg)))
        else $error("walk pointer past end of list");

    a_lists_emptied: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ssi_pkg::ST_DONE) && can_emit) |=>
            ((a_count_reg == '0) && (b_count_reg == '0)
             && out_valid_reg && is_last_reg))
        else $error("summary not issued or lists not emptied");

    a_match_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ssi_pkg::ST_CMP) && eq && !can_emit) |=>
            ((state_reg == ssi_pkg::ST_CMP) && $stable(steps_reg)))
        else $error("match dropped while output stalled");

    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (has_match_reg != is_last_reg))
        else $error("output word is both match and summary");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (compare_count_reg < 7'(2 * ssi_pkg::SET_DEPTH)))
        else $error("step count out of range");
`endif

endmodule

`default_nettype wire
